// File: rtl/ctok_pkg.sv
package ctok_pkg;

   // One above the largest identifier length allowed before a split
   localparam int MAX_WORD_LEN = 128;

   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_UNDER   = 8'h5F;

   localparam logic [6:0] LIMIT_RESET = 7'd99;

   typedef enum logic [2:0] {
      MODE_NORMAL  = 3'd0,
      MODE_WORD    = 3'd1,
      MODE_SLASH   = 3'd2,
      MODE_STRING  = 3'd3,
      MODE_LINE    = 3'd4,
      MODE_BLOCK   = 3'd5,
      MODE_STAR    = 3'd6,
      MODE_PREPROC = 3'd7
   } mode_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       token_kind;
      logic       token_first;
      logic       token_last;
      logic       run_last;
   } result_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == CH_UNDER);
   endfunction

   function automatic logic is_alnum(input logic [7:0] b);
      return is_alpha(b) || (b >= 8'h30 && b <= 8'h39);
   endfunction

endpackage

// File: rtl/ctok_if.sv
interface ctok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ctok_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       token_kind;
   logic       token_first;
   logic       token_last;
   logic       run_last;

   modport source (output valid, output out_char, output token_kind, output token_first,
                   output token_last, output run_last, input ready);
   modport sink (input valid, input out_char, input token_kind, input token_first,
                 input token_last, input run_last, output ready);
endinterface

// File: rtl/c_identifier_tokenizer_top.sv
// Channel | Dir | Payload                                                      | Transaction
// req_ch  | in  | text_byte[7:0], end_of_text                                  | valid & ready
// rsp_ch  | out | out_char[7:0], token_kind, token_first, token_last, run_last | valid & ready
// csr     | in  | csr_wr_data[6:0] (max_word_length)                           | csr_wr_en
//
// One byte per cycle while req_ch.ready is high: the scanner state updates in the cycle
// a byte is taken and its zero, one or two results land in a four-entry result queue.
// A result is registered in the queue when its byte is taken; the queue drains one
// result per cycle while rsp_ch.ready is high; a byte with two results needs two pops.
// req_ch.ready is high while the queue holds two entries or fewer, so a stalled
// output side blocks input once three results are waiting. Synchronous reset clears
// the scanner and the queue and sets the length limit to 99.
module c_identifier_tokenizer_top (
   input  logic             clock,
   input  logic             reset,
   ctok_req_if.sink         req_ch,
   ctok_rsp_if.source       rsp_ch,
   input  logic             csr_wr_en,
   input  logic [6:0]       csr_wr_data
);

   localparam int LimCap = ctok_pkg::MAX_WORD_LEN - 1;

   ctok_pkg::mode_type   mode_ff, mode_in;
   logic [7:0]           held_ff, held_in;
   logic                 first_ff, first_in;
   logic [6:0]           len_ff, len_in;
   logic [6:0]           limit_ff;
   logic [6:0]           lim;

   ctok_pkg::result_type queue_ff [4];
   logic [1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [2:0]           count_ff;

   logic                 accept, pop;
   logic [7:0]           b;
   ctok_pkg::result_type res0, res1, tok, held_res, slash_res;
   logic [1:0]           res_cnt;

   // Normal-mode decode of the incoming byte
   ctok_pkg::mode_type   nb_mode;
   logic                 nb_emit, nb_load;

   assign b      = req_ch.text_byte;
   assign accept = req_ch.valid & req_ch.ready;
   assign pop    = rsp_ch.valid & rsp_ch.ready;

   assign req_ch.ready = (count_ff <= 3'd2);

   // Clamp the length limit to the legal range
   always_comb begin
      lim = limit_ff;
      if (limit_ff == 7'd0) begin
         lim = 7'd1;
      end else if (int'(limit_ff) > LimCap) begin
         lim = 7'(LimCap);
      end
   end

   always_comb begin
      nb_mode = ctok_pkg::MODE_NORMAL;
      nb_emit = 1'b0;
      nb_load = 1'b0;
      if (ctok_pkg::is_space(b)) begin
         nb_mode = ctok_pkg::MODE_NORMAL;
      end else if (b == ctok_pkg::CH_QUOTE) begin
         nb_mode = ctok_pkg::MODE_STRING;
      end else if (b == ctok_pkg::CH_SLASH) begin
         nb_mode = ctok_pkg::MODE_SLASH;
      end else if (b == ctok_pkg::CH_HASH) begin
         nb_mode = ctok_pkg::MODE_PREPROC;
      end else if (ctok_pkg::is_alpha(b)) begin
         nb_mode = ctok_pkg::MODE_WORD;
         nb_load = 1'b1;
      end else begin
         nb_emit = 1'b1;
      end
   end

   // Scanner next state and results of one byte
   always_comb begin
      tok       = '{out_char: b, token_kind: 1'b1, token_first: 1'b1,
                    token_last: 1'b1, run_last: 1'b0};
      slash_res = '{out_char: ctok_pkg::CH_SLASH, token_kind: 1'b1, token_first: 1'b1,
                    token_last: 1'b1, run_last: 1'b0};
      held_res  = '{out_char: held_ff, token_kind: 1'b0, token_first: first_ff,
                    token_last: 1'b1, run_last: 1'b0};
      mode_in  = mode_ff;
      held_in  = held_ff;
      first_in = first_ff;
      len_in   = len_ff;
      res0     = '0;
      res1     = '0;
      res_cnt  = 2'd0;

      if (req_ch.end_of_text) begin
         if (mode_ff == ctok_pkg::MODE_WORD) begin
            res0    = held_res;
            res_cnt = 2'd1;
         end else if (mode_ff == ctok_pkg::MODE_SLASH) begin
            res0    = slash_res;
            res_cnt = 2'd1;
         end
         mode_in  = ctok_pkg::MODE_NORMAL;
         held_in  = 8'd0;
         first_in = 1'b0;
         len_in   = 7'd0;
      end else begin
         unique case (mode_ff)
            ctok_pkg::MODE_NORMAL: begin
               mode_in = nb_mode;
               if (nb_load) begin
                  held_in  = b;
                  first_in = 1'b1;
                  len_in   = 7'd1;
               end
               if (nb_emit) begin
                  res0    = tok;
                  res_cnt = 2'd1;
               end
            end
            ctok_pkg::MODE_WORD: begin
               if (ctok_pkg::is_alnum(b) && (len_ff < lim)) begin
                  res0            = held_res;
                  res0.token_last = 1'b0;
                  res_cnt         = 2'd1;
                  held_in         = b;
                  first_in        = 1'b0;
                  len_in          = len_ff + 7'd1;
               end else begin
                  // Close the word, then treat the byte as in normal mode
                  res0     = held_res;
                  res_cnt  = 2'd1;
                  held_in  = 8'd0;
                  first_in = 1'b0;
                  len_in   = 7'd0;
                  mode_in  = nb_mode;
                  if (nb_load) begin
                     held_in  = b;
                     first_in = 1'b1;
                     len_in   = 7'd1;
                  end
                  if (nb_emit) begin
                     res1    = tok;
                     res_cnt = 2'd2;
                  end
               end
            end
            ctok_pkg::MODE_SLASH: begin
               if (b == ctok_pkg::CH_SLASH) begin
                  mode_in = ctok_pkg::MODE_LINE;
               end else if (b == ctok_pkg::CH_STAR) begin
                  mode_in = ctok_pkg::MODE_BLOCK;
               end else begin
                  // Lone slash: emit it, then treat the byte as in normal mode
                  res0    = slash_res;
                  res_cnt = 2'd1;
                  mode_in = nb_mode;
                  if (nb_load) begin
                     held_in  = b;
                     first_in = 1'b1;
                     len_in   = 7'd1;
                  end
                  if (nb_emit) begin
                     res1    = tok;
                     res_cnt = 2'd2;
                  end
               end
            end
            ctok_pkg::MODE_STRING: begin
               if (b == ctok_pkg::CH_QUOTE) begin
                  mode_in = ctok_pkg::MODE_NORMAL;
               end
            end
            ctok_pkg::MODE_LINE, ctok_pkg::MODE_PREPROC: begin
               if (b == ctok_pkg::CH_NEWLINE) begin
                  mode_in = ctok_pkg::MODE_NORMAL;
               end
            end
            ctok_pkg::MODE_BLOCK: begin
               if (b == ctok_pkg::CH_STAR) begin
                  mode_in = ctok_pkg::MODE_STAR;
               end
            end
            ctok_pkg::MODE_STAR: begin
               if (b == ctok_pkg::CH_SLASH) begin
                  mode_in = ctok_pkg::MODE_NORMAL;
               end else if (b != ctok_pkg::CH_STAR) begin
                  mode_in = ctok_pkg::MODE_BLOCK;
               end
            end
            default: begin
               mode_in = ctok_pkg::MODE_NORMAL;
            end
         endcase
      end

      // Mark the final result of this byte
      if (res_cnt == 2'd2) begin
         res1.run_last = 1'b1;
      end else begin
         res0.run_last = 1'b1;
      end
   end

   // Hold scanner state and the length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= ctok_pkg::MODE_NORMAL;
         held_ff  <= 8'd0;
         first_ff <= 1'b0;
         len_ff   <= 7'd0;
         limit_ff <= ctok_pkg::LIMIT_RESET;
      end else begin
         if (accept) begin
            mode_ff  <= mode_in;
            held_ff  <= held_in;
            first_ff <= first_in;
            len_ff   <= len_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   // Push results into the queue
   always_ff @(posedge clock) begin
      if (accept && (res_cnt != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && (res_cnt == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   // Advance queue pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + res_cnt;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         count_ff <= count_ff + (accept ? {1'b0, res_cnt} : 3'd0) - (pop ? 3'd1 : 3'd0);
      end
   end

   assign rsp_ch.valid       = (count_ff != 3'd0);
   assign rsp_ch.out_char    = queue_ff[rd_ptr_ff].out_char;
   assign rsp_ch.token_kind  = queue_ff[rd_ptr_ff].token_kind;
   assign rsp_ch.token_first = queue_ff[rd_ptr_ff].token_first;
   assign rsp_ch.token_last  = queue_ff[rd_ptr_ff].token_last;
   assign rsp_ch.run_last    = queue_ff[rd_ptr_ff].run_last;

endmodule

// File: rtl/ctok_checker.sv
module ctok_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_char,
   input logic       rsp_token_kind,
   input logic       rsp_token_first,
   input logic       rsp_token_last,
   input logic       rsp_run_last
);

   // A pending result stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char))
      else $error("result dropped or changed while stalled");

   // A single-character token is both first and last
   a_single_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind |-> rsp_token_first && rsp_token_last)
      else $error("single-character token without first and last marks");

   // A word that goes on is the only result of its byte
   a_open_word_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_token_last |-> rsp_run_last && !rsp_token_kind)
      else $error("open identifier character not alone in its run");

   // The second result of a byte is queued together with the first
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("run ended without its final result");

   // Reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind c_identifier_tokenizer_top ctok_checker u_ctok_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_char    (rsp_ch.out_char),
   .rsp_token_kind  (rsp_ch.token_kind),
   .rsp_token_first (rsp_ch.token_first),
   .rsp_token_last  (rsp_ch.token_last),
   .rsp_run_last    (rsp_ch.run_last)
);
